// ----- design/dqu_pkg.sv -----
// Shared types and constants for the double-ended queue unit.
package dqu_pkg;

    localparam int WORD_W  = 32;
    localparam int OP_W    = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 5;

    typedef logic signed [WORD_W-1:0] t_word;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH_BACK  = 2'd0,
        OP_PUSH_FRONT = 2'd1,
        OP_POP_BACK   = 2'd2,
        OP_POP_FRONT  = 2'd3
    } t_op;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_CALC = 1'b1
    } t_state;

    typedef struct packed {
        logic en;
        t_op  op;
    } t_cell_ctrl;

endpackage

// ----- design/double_ended_queue_unit.sv -----
// Top level of the double-ended queue unit: a chain of shifting cells.
//
//  channel | valid   | ready   | payload
//  --------+---------+---------+-------------------------------------------------
//  input   | i_valid | o_ready | i_operation, i_push_value
//  output  | o_valid | i_ready | o_status, o_popped_value, o_front_value,
//          |         |         | o_back_value, o_entry_count
//
// Each beat first shifts or loads the cell chain, then, in the gather state, takes
// front and back from the updated chain into the output register.
// The back word comes from an OR over all DEPTH cells, one tail cell marking it.
// Reset clears the valid bits of all cells at once; no clearing pass.
// A stalled output holds the next beat in the gather cycle until it is taken.
module double_ended_queue_unit #(
    parameter int DEPTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [dqu_pkg::OP_W-1:0]     i_operation,
    input  logic signed [dqu_pkg::WORD_W-1:0] i_push_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [dqu_pkg::STAT_W-1:0]   o_status,
    output logic signed [dqu_pkg::WORD_W-1:0] o_popped_value,
    output logic signed [dqu_pkg::WORD_W-1:0] o_front_value,
    output logic signed [dqu_pkg::WORD_W-1:0] o_back_value,
    output logic [dqu_pkg::COUNT_W-1:0]  o_entry_count
);
    import dqu_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);

    t_word      w_data [DEPTH];
    logic       w_valid [DEPTH];
    t_word      w_tail [DEPTH];
    t_word      w_back;
    t_cell_ctrl w_ctrl;
    t_op        w_op;
    logic       w_accept;
    logic       w_empty;
    logic       w_full;
    logic [CW+COUNT_W-1:0] w_count_ext;

    t_state  r_state;
    t_state  n_state;
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    t_status r_status;
    t_status n_status;
    t_word   r_popped;
    t_word   n_popped;
    logic    r_out_valid;
    logic    n_out_valid;
    t_status r_out_status;
    t_status n_out_status;
    t_word   r_out_popped;
    t_word   n_out_popped;
    t_word   r_out_front;
    t_word   n_out_front;
    t_word   r_out_back;
    t_word   n_out_back;
    logic [COUNT_W-1:0] r_out_count;
    logic [COUNT_W-1:0] n_out_count;

    assign w_op        = t_op'(i_operation);
    assign w_empty     = (r_count == '0);
    assign w_full      = (r_count == CW'(DEPTH));
    assign o_ready     = (r_state == S_IDLE);
    assign w_accept    = i_valid && o_ready;
    assign w_count_ext = (CW + COUNT_W)'(r_count);

    for (genvar g = 0; g < DEPTH; g++) begin : g_cell
        t_word w_left_data;
        logic  w_left_valid;
        t_word w_right_data;
        logic  w_right_valid;

        if (g == 0) begin : g_first
            assign w_left_data  = i_push_value;
            assign w_left_valid = 1'b1;
        end else begin : g_mid_l
            assign w_left_data  = w_data[g-1];
            assign w_left_valid = w_valid[g-1];
        end

        if (g == DEPTH - 1) begin : g_last
            assign w_right_data  = '0;
            assign w_right_valid = 1'b0;
        end else begin : g_mid_r
            assign w_right_data  = w_data[g+1];
            assign w_right_valid = w_valid[g+1];
        end

        dqu_cell u_cell (
            .i_clk         (i_clk),
            .i_rst_n       (i_rst_n),
            .i_ctrl        (w_ctrl),
            .i_push_value  (i_push_value),
            .i_left_data   (w_left_data),
            .i_left_valid  (w_left_valid),
            .i_right_data  (w_right_data),
            .i_right_valid (w_right_valid),
            .o_data        (w_data[g]),
            .o_valid       (w_valid[g]),
            .o_tail_data   (w_tail[g])
        );
    end

    always_comb begin
        w_back = '0;
        for (int i = 0; i < DEPTH; i++) begin
            w_back = w_back | w_tail[i];
        end
    end

    always_comb begin
        n_state      = r_state;
        n_count      = r_count;
        n_status     = r_status;
        n_popped     = r_popped;
        n_out_valid  = r_out_valid && !i_ready;
        n_out_status = r_out_status;
        n_out_popped = r_out_popped;
        n_out_front  = r_out_front;
        n_out_back   = r_out_back;
        n_out_count  = r_out_count;
        w_ctrl.en    = 1'b0;
        w_ctrl.op    = w_op;

        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    n_state  = S_CALC;
                    n_popped = '0;
                    unique case (w_op)
                        OP_PUSH_BACK, OP_PUSH_FRONT: begin
                            if (w_full) begin
                                n_status = ST_FULL;
                            end else begin
                                n_status  = ST_DONE;
                                w_ctrl.en = 1'b1;
                                n_count   = r_count + CW'(1);
                            end
                        end
                        OP_POP_BACK, OP_POP_FRONT: begin
                            if (w_empty) begin
                                n_status = ST_EMPTY;
                            end else begin
                                n_status  = ST_DONE;
                                w_ctrl.en = 1'b1;
                                n_count   = r_count - CW'(1);
                                n_popped  = (w_op == OP_POP_FRONT) ? w_data[0] : w_back;
                            end
                        end
                        default: begin
                            n_status = ST_DONE;
                        end
                    endcase
                end
            end
            S_CALC: begin
                if (!r_out_valid || i_ready) begin
                    n_state      = S_IDLE;
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_popped = r_popped;
                    n_out_front  = w_empty ? '1 : w_data[0];
                    n_out_back   = w_empty ? '1 : w_back;
                    n_out_count  = w_count_ext[COUNT_W-1:0];
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status     <= n_status;
        r_popped     <= n_popped;
        r_out_status <= n_out_status;
        r_out_popped <= n_out_popped;
        r_out_front  <= n_out_front;
        r_out_back   <= n_out_back;
        r_out_count  <= n_out_count;
    end

    assign o_valid        = r_out_valid;
    assign o_status       = r_out_status;
    assign o_popped_value = r_out_popped;
    assign o_front_value  = r_out_front;
    assign o_back_value   = r_out_back;
    assign o_entry_count  = r_out_count;

endmodule

// ----- design/dqu_cell.sv -----
// One storage cell of the deque chain: holds a word and its valid bit.
module dqu_cell (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dqu_pkg::t_cell_ctrl i_ctrl,
    input  dqu_pkg::t_word      i_push_value,
    input  dqu_pkg::t_word      i_left_data,
    input  logic                i_left_valid,
    input  dqu_pkg::t_word      i_right_data,
    input  logic                i_right_valid,
    output dqu_pkg::t_word      o_data,
    output logic                o_valid,
    output dqu_pkg::t_word      o_tail_data
);
    import dqu_pkg::*;

    t_word r_data;
    t_word n_data;
    logic  r_valid;
    logic  n_valid;

    always_comb begin
        n_data  = r_data;
        n_valid = r_valid;
        if (i_ctrl.en) begin
            unique case (i_ctrl.op)
                OP_PUSH_FRONT: begin
                    n_data  = i_left_data;
                    n_valid = i_left_valid;
                end
                OP_POP_FRONT: begin
                    n_data  = i_right_data;
                    n_valid = i_right_valid;
                end
                OP_PUSH_BACK: begin
                    if (!r_valid && i_left_valid) begin
                        n_data  = i_push_value;
                        n_valid = 1'b1;
                    end
                end
                OP_POP_BACK: begin
                    if (r_valid && !i_right_valid) begin
                        n_valid = 1'b0;
                    end
                end
                default: begin
                    n_valid = r_valid;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_data <= n_data;
    end

    assign o_data      = r_data;
    assign o_valid     = r_valid;
    assign o_tail_data = (r_valid && !i_right_valid) ? r_data : '0;

endmodule

// ----- design/dqu_checker.sv -----
// Port-level checks for the double-ended queue unit, bound to the top level.
module dqu_checker #(
    parameter int DEPTH = 16
) (
    input logic                              i_clk,
    input logic                              i_rst_n,
    input logic                              i_valid,
    input logic                              o_ready,
    input logic                              o_valid,
    input logic                              i_ready,
    input logic [dqu_pkg::STAT_W-1:0]        o_status,
    input logic signed [dqu_pkg::WORD_W-1:0] o_popped_value,
    input logic signed [dqu_pkg::WORD_W-1:0] o_front_value,
    input logic signed [dqu_pkg::WORD_W-1:0] o_back_value,
    input logic [dqu_pkg::COUNT_W-1:0]       o_entry_count
);
    import dqu_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status) && $stable(o_popped_value)
            && $stable(o_front_value) && $stable(o_back_value) && $stable(o_entry_count))
        else $error("result beat changed while stalled");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("input taken again before the previous beat was processed");

    a_empty_pop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_EMPTY |-> o_popped_value == '0 && o_entry_count == '0
            && o_front_value == -1 && o_back_value == -1)
        else $error("refused pop reported a non-empty deque");

    a_full_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_FULL |-> o_entry_count == COUNT_W'(DEPTH)
            && o_popped_value == '0)
        else $error("dropped push reported a count other than full");

    a_single_entry: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (DEPTH < 32) && o_valid && o_entry_count == COUNT_W'(1)
            |-> o_front_value == o_back_value)
        else $error("single entry shows different front and back");

endmodule

bind double_ended_queue_unit dqu_checker #(.DEPTH(DEPTH)) u_dqu_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_ready        (o_ready),
    .o_valid        (o_valid),
    .i_ready        (i_ready),
    .o_status       (o_status),
    .o_popped_value (o_popped_value),
    .o_front_value  (o_front_value),
    .o_back_value   (o_back_value),
    .o_entry_count  (o_entry_count)
);
